@@ hdl/dmac4_pkg.sv @@
package dmac4_pkg;

    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRIGGER   = 2'd1;
    localparam logic [1:0] KIND_FIFO      = 2'd2;
    localparam logic [1:0] KIND_TICK      = 2'd3;

    localparam logic [3:0] SUB_SRC_LO  = 4'd0;
    localparam logic [3:0] SUB_SRC_HI  = 4'd2;
    localparam logic [3:0] SUB_DST_LO  = 4'd4;
    localparam logic [3:0] SUB_DST_HI  = 4'd6;
    localparam logic [3:0] SUB_COUNT   = 4'd8;
    localparam logic [3:0] SUB_CONTROL = 4'd10;

    localparam logic [1:0] MODE_INC   = 2'd0;
    localparam logic [1:0] MODE_DEC   = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    localparam logic [1:0] TIMING_FIFO = 2'd3;

    localparam int CTRL_ENABLE = 15;
    localparam int CTRL_IRQ    = 14;
    localparam int CTRL_WORD   = 10;
    localparam int CTRL_REPEAT = 9;

    // Working copies of one channel, kept together in one memory entry.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [16:0] count;
    } t_work;

    function automatic logic [31:0] f_advance(input logic [31:0] addr,
                                              input logic [1:0] mode,
                                              input logic [2:0] step);
        logic [31:0] r;
        begin
            case (mode)
                MODE_DEC:   r = addr - {29'd0, step};
                MODE_FIXED: r = addr;
                default:    r = addr + {29'd0, step};
            endcase
            return r;
        end
    endfunction

endpackage

@@ hdl/four_channel_dma_controller_top.sv @@
// Four-channel DMA controller.
// One input request channel (valid/ready) carries register writes, timing
// triggers, sound FIFO requests and transfer ticks; every accepted request
// yields exactly one result on the output channel (valid/ready). A tick with
// an active or pending channel yields one aligned halfword or word copy.
// Working source, destination and count of all channels sit in one
// synchronous memory with a registered read port. The memory read starts at
// the edge that accepts a request into the fetch register, and the execute
// step does the read-modify-write once the output register is free; a write
// back to the entry just read is forwarded, so a new request can be accepted
// every cycle while the receiver does not stall. Each result is registered
// in the output register, and throughput is one request per cycle without stalls.
// When the receiver stalls the output register holds, the execute stage
// holds, and ready drops once both the output register and the execute
// stage are full, so no result is lost. Reset clears the latches, control
// words, pending bits and the working memory's valid bits; there is no
// clearing pass and the block takes requests right after reset.
module four_channel_dma_controller_top
    import dmac4_pkg::*;
#(
    parameter int NUM_CHANNELS     = 4,
    parameter int FIFO_BURST_WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_reg_offset,
    input  logic [15:0] i_write_value,
    input  logic [1:0]  i_timing_event,
    input  logic        i_fifo_select,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_xfer_valid,
    output logic [31:0] o_src_addr,
    output logic [31:0] o_dst_addr,
    output logic        o_word_size,
    output logic [1:0]  o_xfer_channel,
    output logic        o_run_last,
    output logic [3:0]  o_irq_request,
    output logic [3:0]  o_enabled_mask
);

    localparam int BW = $clog2(FIFO_BURST_WORDS + 1);

    // Fetch stage: the request waiting for its memory read.
    logic        r_f_vld;
    logic [1:0]  r_f_kind;
    logic [5:0]  r_f_off;
    logic [15:0] r_f_val;
    logic [1:0]  r_f_tev;
    logic        r_f_fsel;

    // Output register.
    logic        r_o_vld;
    logic        r_xv, r_ws, r_last;
    logic [31:0] r_sa, r_da;
    logic [1:0]  r_xch;
    logic [3:0]  r_irq, r_en;

    // Control state in flip-flops; working copies in the memory.
    logic [27:0] r_src_l [4];
    logic [27:0] r_dst_l [4];
    logic [15:0] r_cnt_l [4];
    logic [15:0] r_ctrl  [4];
    logic [3:0]  r_prun, r_pfifo, r_wvalid;
    logic [2:0]  r_act;
    logic [BW-1:0] r_bleft;

    t_work       r_mem [4];
    t_work       r_rd;
    logic [1:0]  r_rd_ch;
    logic        r_rd_fwd_vld;
    t_work       r_fwd;

    // Which entry the fetch stage reads: the channel a request may touch.
    logic [1:0]  rd_addr;
    logic [1:0]  ch_of_off;

    always_comb begin
        if (i_reg_offset < 6'd12) begin
            ch_of_off = 2'd0;
        end else if (i_reg_offset < 6'd24) begin
            ch_of_off = 2'd1;
        end else if (i_reg_offset < 6'd36) begin
            ch_of_off = 2'd2;
        end else begin
            ch_of_off = 2'd3;
        end
    end

    // The tick channel is predicted before execute, so a tick reads one lane:
    // the memory is four entries, and a tick's entry is picked from the
    // forwarded copy and one read port by prediction below.
    logic        accept_in, out_free, exe_go;
    logic [1:0]  tick_pick;

    assign out_free  = !r_o_vld || i_ready;
    assign exe_go    = r_f_vld && out_free;
    assign o_ready   = !r_f_vld || out_free;
    assign accept_in = i_valid && o_ready;

    // Execute-stage combinational update.
    logic [2:0]  n_act;
    logic [BW-1:0] n_bleft;
    logic [3:0]  n_prun, n_pfifo;
    logic [15:0] n_ctrl [4];
    logic [27:0] n_src_l [4];
    logic [27:0] n_dst_l [4];
    logic [15:0] n_cnt_l [4];
    logic        wr_en;
    logic [1:0]  wr_ch;
    t_work       wr_data;
    logic        xv, ws, last;
    logic [31:0] sa, da;
    logic [1:0]  xch;
    logic [3:0]  irq;
    t_work       cur;
    logic [3:0]  fch, fsub;
    logic [2:0]  step;
    logic [16:0] fullc;
    logic        burst;
    logic [BW-1:0] left;
    logic [1:0]  smode, dmode;
    logic [15:0] c;
    logic        word;

    // Entry read in fetch; next tick's channel is the active one if any,
    // else lowest pending (computed from state as it will stand).
    always_comb begin
        tick_pick = 2'd0;
        if (n_act < 3'd4) begin
            tick_pick = n_act[1:0];
        end else begin
            for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
                if (n_pfifo[k] || n_prun[k]) tick_pick = 2'(k);
            end
        end
    end

    // When a request reaches execute, the read data belongs to rd_ch.
    always_comb begin
        if (exe_go || !r_f_vld) begin
            rd_addr = (i_kind == KIND_TICK) ? tick_pick : ch_of_off;
        end else begin
            rd_addr = r_rd_ch;
        end
    end

    always_comb begin
        n_act   = r_act;
        n_bleft = r_bleft;
        n_prun  = r_prun;
        n_pfifo = r_pfifo;
        for (int k = 0; k < 4; k++) begin
            n_ctrl[k]  = r_ctrl[k];
            n_src_l[k] = r_src_l[k];
            n_dst_l[k] = r_dst_l[k];
            n_cnt_l[k] = r_cnt_l[k];
        end
        wr_en = 1'b0; wr_ch = r_rd_ch; wr_data = '0;
        xv = 1'b0; ws = 1'b0; last = 1'b0; sa = '0; da = '0; xch = '0; irq = '0;
        fch = 4'd0; fsub = 4'd0; step = 3'd2; fullc = '0; burst = 1'b0;
        left = '0; smode = '0; dmode = '0; c = '0; word = 1'b0;
        cur = r_rd_fwd_vld ? r_fwd : (r_wvalid[r_rd_ch] ? r_rd : '0);

        if (r_f_vld) begin
            unique case (r_f_kind)
                KIND_REG_WRITE: begin
                    if (r_f_off < 6'd12) begin
                        fch = 4'd0; fsub = r_f_off[3:0];
                    end else if (r_f_off < 6'd24) begin
                        fch = 4'd1; fsub = 4'(r_f_off - 6'd12);
                    end else if (r_f_off < 6'd36) begin
                        fch = 4'd2; fsub = 4'(r_f_off - 6'd24);
                    end else begin
                        fch = 4'd3; fsub = 4'(r_f_off - 6'd36);
                    end
                    if (r_f_off < 6'd48 && 32'(fch) < NUM_CHANNELS) begin
                        case (fsub)
                            SUB_SRC_LO: n_src_l[fch[1:0]][15:0] = r_f_val;
                            SUB_SRC_HI: n_src_l[fch[1:0]][27:16] =
                                (fch == 4'd3) ? r_f_val[11:0]
                                              : {1'b0, r_f_val[10:0]};
                            SUB_DST_LO: n_dst_l[fch[1:0]][15:0] = r_f_val;
                            SUB_DST_HI: n_dst_l[fch[1:0]][27:16] =
                                (fch == 4'd3) ? r_f_val[11:0]
                                              : {1'b0, r_f_val[10:0]};
                            SUB_COUNT: n_cnt_l[fch[1:0]] = (fch == 4'd3) ?
                                r_f_val : {2'b00, r_f_val[13:0]};
                            SUB_CONTROL: begin
                                n_ctrl[fch[1:0]] = r_f_val;
                                if (!r_ctrl[fch[1:0]][CTRL_ENABLE]
                                    && r_f_val[CTRL_ENABLE]) begin
                                    c = r_cnt_l[fch[1:0]];
                                    wr_en = 1'b1; wr_ch = fch[1:0];
                                    wr_data.src = {4'd0, r_src_l[fch[1:0]]};
                                    wr_data.dst = {4'd0, r_dst_l[fch[1:0]]};
                                    wr_data.count = (c != 16'd0) ? {1'b0, c} :
                                        ((fch == 4'd3) ? 17'h10000 : 17'h04000);
                                    if (r_f_val[13:12] == 2'd0)
                                        n_prun[fch[1:0]] = 1'b1;
                                end
                                if (!r_f_val[CTRL_ENABLE]) begin
                                    n_prun[fch[1:0]]  = 1'b0;
                                    n_pfifo[fch[1:0]] = 1'b0;
                                    if (r_act == {1'b0, fch[1:0]}) begin
                                        n_act = 3'd4; n_bleft = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_TRIGGER: begin
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (r_ctrl[k][CTRL_ENABLE] && r_ctrl[k][13:12] == r_f_tev)
                            n_prun[k] = 1'b1;
                    end
                end
                KIND_FIFO: begin
                    if (32'(r_f_fsel) + 1 < NUM_CHANNELS
                        && r_ctrl[2'(r_f_fsel) + 2'd1][CTRL_ENABLE]
                        && r_ctrl[2'(r_f_fsel) + 2'd1][13:12] == TIMING_FIFO)
                        n_pfifo[2'(r_f_fsel) + 2'd1] = 1'b1;
                end
                KIND_TICK: begin
                    if (r_act >= 3'd4) begin
                        if (r_pfifo[r_rd_ch] || r_prun[r_rd_ch]) begin
                            n_act = {1'b0, r_rd_ch};
                            if (r_pfifo[r_rd_ch]) begin
                                n_pfifo[r_rd_ch] = 1'b0;
                                burst = 1'b1; left = BW'(FIFO_BURST_WORDS);
                            end else begin
                                n_prun[r_rd_ch] = 1'b0;
                                if (cur.count == 17'd0) begin
                                    c = r_cnt_l[r_rd_ch];
                                    cur.count = (c != 16'd0) ? {1'b0, c} :
                                        ((r_rd_ch == 2'd3) ? 17'h10000 : 17'h04000);
                                end
                            end
                        end
                    end else if (r_bleft != '0) begin
                        burst = 1'b1; left = r_bleft;
                    end
                    if (n_act < 3'd4) begin
                        smode = r_ctrl[r_rd_ch][8:7];
                        dmode = r_ctrl[r_rd_ch][6:5];
                        xv = 1'b1; xch = r_rd_ch;
                        wr_en = 1'b1; wr_ch = r_rd_ch; wr_data = cur;
                        if (burst) begin
                            ws = 1'b1;
                            sa = {cur.src[31:2], 2'b00};
                            da = {cur.dst[31:2], 2'b00};
                            wr_data.src = f_advance(cur.src, smode, 3'd4);
                            left = left - BW'(1);
                            n_bleft = left;
                            if (left == '0) begin
                                last = 1'b1; n_act = 3'd4;
                            end
                        end else begin
                            word = r_ctrl[r_rd_ch][CTRL_WORD];
                            step = word ? 3'd4 : 3'd2;
                            ws = word;
                            sa = {cur.src[31:2], word ? 1'b0 : cur.src[1], 1'b0};
                            da = {cur.dst[31:2], word ? 1'b0 : cur.dst[1], 1'b0};
                            wr_data.src = f_advance(cur.src, smode, step);
                            wr_data.dst = f_advance(cur.dst, dmode, step);
                            wr_data.count = (cur.count > 17'd1) ?
                                cur.count - 17'd1 : 17'd0;
                            if (wr_data.count == 17'd0) begin
                                last = 1'b1; n_act = 3'd4;
                                if (dmode == MODE_RELOAD)
                                    wr_data.dst = {4'd0, r_dst_l[r_rd_ch]};
                                if (r_ctrl[r_rd_ch][CTRL_IRQ])
                                    irq[r_rd_ch] = 1'b1;
                                if (r_ctrl[r_rd_ch][CTRL_REPEAT]) begin
                                    c = r_cnt_l[r_rd_ch];
                                    wr_data.count = (c != 16'd0) ? {1'b0, c} :
                                        ((r_rd_ch == 2'd3) ? 17'h10000 : 17'h04000);
                                end else begin
                                    n_ctrl[r_rd_ch][CTRL_ENABLE] = 1'b0;
                                    n_prun[r_rd_ch]  = 1'b0;
                                    n_pfifo[r_rd_ch] = 1'b0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!exe_go) begin
            n_act = r_act; n_bleft = r_bleft; n_prun = r_prun; n_pfifo = r_pfifo;
            for (int k = 0; k < 4; k++) begin
                n_ctrl[k]  = r_ctrl[k];
                n_src_l[k] = r_src_l[k];
                n_dst_l[k] = r_dst_l[k];
                n_cnt_l[k] = r_cnt_l[k];
            end
            wr_en = 1'b0;
        end
    end

    // Working-copy memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_ch] <= wr_data;
        end
        r_rd    <= r_mem[rd_addr];
        r_rd_ch <= rd_addr;
        r_fwd   <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld      <= 1'b0;
            r_o_vld      <= 1'b0;
            r_prun       <= '0;
            r_pfifo      <= '0;
            r_wvalid     <= '0;
            r_act        <= 3'd4;
            r_bleft      <= '0;
            r_rd_fwd_vld <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_src_l[k] <= '0;
                r_dst_l[k] <= '0;
                r_cnt_l[k] <= '0;
                r_ctrl[k]  <= '0;
            end
        end else begin
            r_act   <= n_act;
            r_bleft <= n_bleft;
            r_prun  <= n_prun;
            r_pfifo <= n_pfifo;
            for (int k = 0; k < 4; k++) begin
                r_src_l[k] <= n_src_l[k];
                r_dst_l[k] <= n_dst_l[k];
                r_cnt_l[k] <= n_cnt_l[k];
                r_ctrl[k]  <= n_ctrl[k];
            end
            if (wr_en) begin
                r_wvalid[wr_ch] <= 1'b1;
            end
            // Forward the write when the next read targets the same entry.
            r_rd_fwd_vld <= wr_en && (wr_ch == rd_addr);
            r_f_vld <= accept_in || (r_f_vld && !exe_go);
            r_o_vld <= exe_go || (r_o_vld && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_f_kind <= i_kind;
            r_f_off  <= i_reg_offset;
            r_f_val  <= i_write_value;
            r_f_tev  <= i_timing_event;
            r_f_fsel <= i_fifo_select;
        end
        if (exe_go) begin
            r_xv   <= xv;
            r_sa   <= sa;
            r_da   <= da;
            r_ws   <= ws;
            r_xch  <= xch;
            r_last <= last;
            r_irq  <= irq;
            for (int k = 0; k < 4; k++) begin
                r_en[k] <= n_ctrl[k][CTRL_ENABLE];
            end
        end
    end

    assign o_valid        = r_o_vld;
    assign o_xfer_valid   = r_xv;
    assign o_src_addr     = r_sa;
    assign o_dst_addr     = r_da;
    assign o_word_size    = r_ws;
    assign o_xfer_channel = r_xch;
    assign o_run_last     = r_last;
    assign o_irq_request  = r_irq;
    assign o_enabled_mask = r_en;

endmodule
